FILE: src/assert_macros.svh
// Assertion helpers for the RTL top level; clocked on clk_i, held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop on every clock edge outside reset
`define RPRA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// check cons in the cycle after ante
`define RPRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/rpra_pkg.sv
package rpra_pkg;

  localparam int NUM_REGIONS = 16;
  localparam int POOL_PAGES  = 16;
  localparam int SUB_W       = 4;
  localparam int SLOT_W      = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int PAGE_W      = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int ENTRY_W     = SLOT_W + SUB_W;
  localparam int NUM_ENTRIES = NUM_REGIONS * (2 ** SUB_W);
  localparam int CNT_W       = 5;
  localparam int TAG_W       = 12;

  localparam logic [4:0]  REGIONS_RESET = 5'd16;
  localparam logic [4:0]  LIMIT_RESET   = 5'd16;
  localparam logic [15:0] BASE_RESET    = 16'd0;
  localparam logic [16:0] SUBPAGE_BYTES = 17'h10000;

  typedef enum logic [2:0] {
    ST_NEW_PAGE  = 3'd0,
    ST_REUSED    = 3'd1,
    ST_SPANS     = 3'd2,
    ST_NO_FREE   = 3'd3,
    ST_EXHAUSTED = 3'd4,
    ST_NO_SLOTS  = 3'd5,
    ST_HIT       = 3'd6,
    ST_MISS      = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    CFG_REGIONS_ENABLED = 2'd0,
    CFG_PAGE_LIMIT      = 2'd1,
    CFG_POOL_BASE       = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_MAP    = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_e;

  typedef struct packed {
    logic capture;
    logic match;
    logic select;
    logic finish;
  } cmd_t;

endpackage

FILE: src/rpra_ctrl.sv
module rpra_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output rpra_pkg::cmd_t cmd_o
);
  import rpra_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MATCH  = 4'b0010,
    S_SELECT = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = S_SELECT;
      end
      S_SELECT: begin
        cmd_o.select = 1'b1;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

FILE: src/rpra_dp.sv
module rpra_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rpra_pkg::cmd_t cmd_i,
  input  logic           kind_i,
  input  logic [31:0]    addr_i,
  input  logic [16:0]    size_i,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [15:0]    cfg_data_i,
  output logic           result_valid_o,
  output logic [2:0]     status_o,
  output logic [3:0]     slot_o,
  output logic [3:0]     page_number_o,
  output logic [31:0]    backing_addr_o,
  output logic           copy_needed_o
);
  import rpra_pkg::*;

  // configuration
  logic [4:0]  regions_enabled_q;
  logic [4:0]  page_limit_q;
  logic [15:0] pool_base_q;

  // transaction
  logic        kind_q;
  logic [31:0] addr_q;
  logic [16:0] size_q;

  // region and sub-page state
  logic [NUM_REGIONS-1:0] region_valid_q;
  logic [TAG_W-1:0]       region_tag_q [NUM_REGIONS];
  logic [NUM_ENTRIES-1:0] subpage_valid_q;
  logic [PAGE_W-1:0]      page_mem [NUM_ENTRIES];
  logic [CNT_W-1:0]       pages_q;

  // search pipeline
  logic [NUM_REGIONS-1:0] match_q, match_d;
  logic [NUM_REGIONS-1:0] free_q, free_d;
  logic                   span_q;
  logic [16:0]            span_sum;
  logic [SLOT_W-1:0]      lo_match, hi_match, lo_free, slot_sel;
  logic [SLOT_W-1:0]      slot_q;
  logic                   found_q, found_sel;
  logic                   have_free_q;
  logic                   sp_valid_q;
  logic [PAGE_W-1:0]      page_rd_q;
  logic [ENTRY_W-1:0]     rd_entry, wr_entry;

  // finish decision
  status_e            res_status;
  logic               res_ok;
  logic               do_alloc;
  logic [PAGE_W-1:0]  res_page;
  logic               exhausted;
  logic [15:0]        res_frame;

  // result registers
  logic        result_valid_q;
  status_e     status_q;
  logic [3:0]  slot_out_q;
  logic [3:0]  page_out_q;
  logic [31:0] backing_q;
  logic        copy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regions_enabled_q <= REGIONS_RESET;
      page_limit_q      <= LIMIT_RESET;
      pool_base_q       <= BASE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_REGIONS_ENABLED: regions_enabled_q <= cfg_data_i[4:0];
        CFG_PAGE_LIMIT:      page_limit_q      <= cfg_data_i[4:0];
        CFG_POOL_BASE:       pool_base_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      addr_q <= addr_i;
      size_q <= size_i;
    end
  end

  assign span_sum = {1'b0, addr_q[15:0]} + size_q;

  always_comb begin
    for (int s = 0; s < NUM_REGIONS; s++) begin
      match_d[s] = (32'(s) < 32'(regions_enabled_q)) && region_valid_q[s] &&
                   (region_tag_q[s] == addr_q[31:20]);
      free_d[s]  = (32'(s) < 32'(regions_enabled_q)) && !region_valid_q[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.match) begin
      match_q <= match_d;
      free_q  <= free_d;
      span_q  <= (span_sum > SUBPAGE_BYTES);
    end
  end

  always_comb begin
    lo_match = '0;
    hi_match = '0;
    lo_free  = '0;
    for (int s = NUM_REGIONS - 1; s >= 0; s--) begin
      if (match_q[s]) lo_match = SLOT_W'(s);
      if (free_q[s])  lo_free  = SLOT_W'(s);
    end
    for (int s = 0; s < NUM_REGIONS; s++) begin
      if (match_q[s]) hi_match = SLOT_W'(s);
    end
  end

  always_comb begin
    found_sel = |match_q;
    if (kind_q == KIND_LOOKUP) begin
      slot_sel = lo_match;
    end else if (found_sel) begin
      slot_sel = hi_match;
    end else begin
      slot_sel = lo_free;
    end
  end

  assign rd_entry = {slot_sel, addr_q[19:16]};
  assign wr_entry = {slot_q, addr_q[19:16]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.select) begin
      slot_q      <= slot_sel;
      found_q     <= found_sel;
      have_free_q <= |free_q;
      sp_valid_q  <= subpage_valid_q[rd_entry];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_alloc) begin
      page_mem[wr_entry] <= PAGE_W'(pages_q);
    end
    if (cmd_i.select) begin
      page_rd_q <= page_mem[rd_entry];
    end
  end

  assign exhausted = (pages_q >= page_limit_q) || (32'(pages_q) >= 32'(POOL_PAGES));

  always_comb begin
    res_status = ST_MISS;
    res_ok     = 1'b0;
    do_alloc   = 1'b0;
    res_page   = page_rd_q;
    if (kind_q == KIND_LOOKUP) begin
      if (found_q && sp_valid_q) begin
        res_status = ST_HIT;
        res_ok     = 1'b1;
      end
    end else if (regions_enabled_q == '0) begin
      res_status = ST_NO_SLOTS;
    end else if (span_q) begin
      res_status = ST_SPANS;
    end else if (!found_q && !have_free_q) begin
      res_status = ST_NO_FREE;
    end else if (sp_valid_q) begin
      res_status = ST_REUSED;
      res_ok     = 1'b1;
    end else if (exhausted) begin
      res_status = ST_EXHAUSTED;
    end else begin
      res_status = ST_NEW_PAGE;
      res_ok     = 1'b1;
      res_page   = PAGE_W'(pages_q);
      do_alloc   = cmd_i.finish;
    end
  end

  assign res_frame = pool_base_q + 16'(res_page);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_valid_q  <= '0;
      subpage_valid_q <= '0;
      pages_q         <= '0;
      result_valid_q  <= 1'b0;
    end else begin
      result_valid_q <= cmd_i.finish;
      if (do_alloc) begin
        region_valid_q[slot_q]    <= 1'b1;
        subpage_valid_q[wr_entry] <= 1'b1;
        pages_q                   <= pages_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_alloc && !found_q) begin
      region_tag_q[slot_q] <= addr_q[31:20];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q   <= res_status;
      slot_out_q <= res_ok ? 4'(slot_q) : 4'd0;
      page_out_q <= res_ok ? 4'(res_page) : 4'd0;
      backing_q  <= res_ok ? {res_frame, addr_q[15:0]} : 32'd0;
      copy_q     <= (res_status == ST_NEW_PAGE);
    end
  end

  assign result_valid_o = result_valid_q;
  assign status_o       = status_q;
  assign slot_o         = slot_out_q;
  assign page_number_o  = page_out_q;
  assign backing_addr_o = backing_q;
  assign copy_needed_o  = copy_q;

endmodule

FILE: src/rom_patch_remap_allocator.sv
// Channel   Handshake                    Payload
// request   start / busy                 kind_i, addr_i, size_i
// result    result_valid_o (one cycle)   status_o, slot_o, page_number_o,
//                                        backing_addr_o, copy_needed_o
// config    cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// One transaction at a time, in order: accept, parallel tag compare over the
// region slots, priority select with sub-page memory read, decide and update.
// The result strobe is registered from the decide step; busy is low again in
// the cycle the result is shown, so the next request may start then.
// Asynchronous active-low reset clears all slots, sub-pages and the page count.
// The receiver cannot stall; configuration is taken whenever busy is low.
`include "assert_macros.svh"

module rom_patch_remap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [31:0] addr_i,
  input  logic [16:0] size_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic [3:0]  slot_o,
  output logic [3:0]  page_number_o,
  output logic [31:0] backing_addr_o,
  output logic        copy_needed_o
);
  import rpra_pkg::*;

  cmd_t cmd;
  logic busy_int;

  rpra_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy_int),
    .cmd_o   (cmd)
  );

  rpra_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .kind_i         (kind_i),
    .addr_i         (addr_i),
    .size_i         (size_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .page_number_o  (page_number_o),
    .backing_addr_o (backing_addr_o),
    .copy_needed_o  (copy_needed_o)
  );

  assign busy        = busy_int;
  assign cfg_ready_o = !busy_int;

  `RPRA_ASSERT(a_result_latency, (start && !busy) |-> ##4 result_valid_o, "result missing")
  `RPRA_ASSERT(a_result_idle, result_valid_o |-> !busy, "result while busy")
  `RPRA_ASSERT_NEXT(a_single_result, result_valid_o, !result_valid_o, "repeated result")
  `RPRA_ASSERT(a_busy_after_start, $rose(busy) |-> $past(start), "busy without start")

endmodule

FILE: sim/tb.sv
module tb;
  import rpra_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct {
    status_e     status;
    logic [3:0]  slot;
    logic [3:0]  page;
    logic [31:0] backing;
    logic        copy;
  } grant_t;

  class remap_tracker;
    bit                slot_used[NUM_REGIONS];
    logic [TAG_W-1:0]  slot_tag[NUM_REGIONS];
    bit                sub_used[NUM_ENTRIES];
    logic [PAGE_W-1:0] sub_page[NUM_ENTRIES];
    int                pages_given;
    logic [4:0]        slots_on;
    logic [4:0]        page_cap;
    logic [15:0]       base_frame;
    grant_t            awaited[$];
    int unsigned       failures;

    function new();
      slots_on = REGIONS_RESET;
      page_cap = LIMIT_RESET;
      base_frame = BASE_RESET;
      pages_given = 0;
      failures = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      foreach (slot_tag[i]) slot_tag[i] = '0;
      foreach (sub_used[i]) sub_used[i] = 1'b0;
      foreach (sub_page[i]) sub_page[i] = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_REGIONS_ENABLED: slots_on = data[4:0];
        CFG_PAGE_LIMIT:      page_cap = data[4:0];
        CFG_POOL_BASE:       base_frame = data;
        default: ;
      endcase
    endfunction

    function grant_t granted(status_e st, int slot, int page, logic [31:0] addr);
      grant_t g;
      logic [15:0] frame;
      frame = base_frame + 16'(page);
      g.status = st;
      g.slot = 4'(slot);
      g.page = 4'(page);
      g.backing = {frame, addr[15:0]};
      g.copy = (st == ST_NEW_PAGE);
      return g;
    endfunction

    function void note_request(kind_e kind, logic [31:0] addr, logic [16:0] size);
      grant_t g;
      int n, cap, slot, free_slot, e, sub;
      bit found, have_free;
      logic [TAG_W-1:0] tag;
      tag = addr[31:20];
      sub = int'(addr[19:16]);
      n = (int'(slots_on) < NUM_REGIONS) ? int'(slots_on) : NUM_REGIONS;
      cap = (int'(page_cap) < POOL_PAGES) ? int'(page_cap) : POOL_PAGES;
      g = '{ST_MISS, 4'd0, 4'd0, 32'd0, 1'b0};
      found = 1'b0;
      have_free = 1'b0;
      slot = 0;
      free_slot = 0;
      if (kind == KIND_LOOKUP) begin
        for (int i = 0; i < n; i++) begin
          if (slot_used[i] && slot_tag[i] == tag) begin
            e = (i << SUB_W) + sub;
            if (sub_used[e]) g = granted(ST_HIT, i, int'(sub_page[e]), addr);
            break;
          end
        end
      end else if (n == 0) begin
        g.status = ST_NO_SLOTS;
      end else if (int'(addr[15:0]) + int'(size) > int'(SUBPAGE_BYTES)) begin
        g.status = ST_SPANS;
      end else begin
        for (int i = n - 1; i >= 0; i--) begin
          if (slot_used[i] && slot_tag[i] == tag) begin
            slot = i;
            found = 1'b1;
            break;
          end
          if (!slot_used[i]) begin
            free_slot = i;
            have_free = 1'b1;
          end
        end
        if (!found && !have_free) begin
          g.status = ST_NO_FREE;
        end else begin
          if (!found) slot = free_slot;
          e = (slot << SUB_W) + sub;
          if (sub_used[e]) begin
            g = granted(ST_REUSED, slot, int'(sub_page[e]), addr);
          end else if (pages_given >= cap) begin
            g.status = ST_EXHAUSTED;
          end else begin
            if (!found) begin
              slot_used[slot] = 1'b1;
              slot_tag[slot] = tag;
            end
            sub_used[e] = 1'b1;
            sub_page[e] = PAGE_W'(pages_given);
            g = granted(ST_NEW_PAGE, slot, pages_given, addr);
            pages_given++;
          end
        end
      end
      awaited.push_back(g);
    endfunction

    function void check_result(logic [2:0] status, logic [3:0] slot, logic [3:0] page,
                               logic [31:0] backing, logic copy);
      grant_t g;
      if (awaited.size() == 0) begin
        $error("result transaction with no request outstanding");
        failures++;
        return;
      end
      g = awaited.pop_front();
      if (status !== g.status) begin
        $error("status: expected %0d, got %0d", g.status, status);
        failures++;
      end
      if (slot !== g.slot) begin
        $error("slot: expected %0d, got %0d", g.slot, slot);
        failures++;
      end
      if (page !== g.page) begin
        $error("page_number: expected %0d, got %0d", g.page, page);
        failures++;
      end
      if (backing !== g.backing) begin
        $error("backing_addr: expected %08h, got %08h", g.backing, backing);
        failures++;
      end
      if (copy !== g.copy) begin
        $error("copy_needed: expected %0d, got %0d", g.copy, copy);
        failures++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        kind_i = 1'b0;
  logic [31:0] addr_i = '0;
  logic [16:0] size_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        busy;
  logic        cfg_ready_o;
  logic        result_valid_o;
  logic [2:0]  status_o;
  logic [3:0]  slot_o;
  logic [3:0]  page_number_o;
  logic [31:0] backing_addr_o;
  logic        copy_needed_o;

  remap_tracker tracker = new();
  int idle_pct = 27;
  logic [TAG_W-1:0] tag_pool[24];

  always #4 clk_i = ~clk_i;

  rom_patch_remap_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .addr_i         (addr_i),
    .size_i         (size_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .page_number_o  (page_number_o),
    .backing_addr_o (backing_addr_o),
    .copy_needed_o  (copy_needed_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) tracker.write_reg(cfg_index_i, cfg_data_i);
      if (start && !busy) tracker.note_request(kind_e'(kind_i), addr_i, size_i);
      if (result_valid_o) begin
        tracker.check_result(status_o, slot_o, page_number_o, backing_addr_o, copy_needed_o);
      end
    end
  end

  task automatic send(kind_e k, logic [31:0] a, logic [16:0] s);
    kind_i <= k;
    addr_i <= a;
    size_i <= s;
    forever begin
      start <= ($urandom_range(99) >= idle_pct);
      @(posedge clk_i);
      if (start && !busy) break;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_count();
    logic [15:0] d;
    d = 16'($urandom);
    case ($urandom_range(11))
      0:       d[4:0] = 5'd0;
      1:       d[4:0] = 5'($urandom_range(17, 31));
      default: d[4:0] = 5'($urandom_range(1, 16));
    endcase
    return d;
  endfunction

  task automatic random_settings();
    logic [15:0] d;
    cfg_write(CFG_REGIONS_ENABLED, pick_count());
    cfg_write(CFG_PAGE_LIMIT, pick_count());
    case ($urandom_range(3))
      0:       d = 16'h0000;
      1:       d = 16'hffff;
      default: d = 16'($urandom);
    endcase
    cfg_write(CFG_POOL_BASE, d);
    if ($urandom_range(3) == 0) cfg_write(CFG_SPARE, 16'($urandom));
  endtask

  task automatic random_item();
    kind_e k;
    logic [31:0] a;
    logic [15:0] low;
    logic [16:0] s;
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) begin
      k = kind_e'($urandom_range(1));
      a = $urandom;
      s = 17'($urandom_range(65536));
    end else begin
      low = 16'($urandom);
      a = {tag_pool[$urandom_range(23)],
           ($urandom_range(99) < 70) ? 4'($urandom_range(2)) : 4'($urandom_range(15)), low};
      k = ($urandom_range(99) < 45) ? KIND_LOOKUP : KIND_MAP;
      if (roll < 20 && low != 16'd0) begin
        s = 17'($urandom_range(65536, 65536 - int'(low) + 1));
      end else begin
        s = 17'($urandom_range(65536 - int'(low)));
      end
    end
    send(k, a, s);
  endtask

  initial begin
    foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom);
    tag_pool[0] = 12'h000;
    tag_pool[1] = 12'hfff;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(KIND_LOOKUP, 32'h0000_0000, 17'd0);
    send(KIND_MAP,    32'h0000_0000, 17'd0);
    send(KIND_MAP,    32'hffff_ffff, 17'd1);
    send(KIND_MAP,    32'hffff_ffff, 17'd2);
    send(KIND_MAP,    32'h0000_0000, 17'h10000);
    send(KIND_MAP,    32'h0000_0001, 17'h10000);
    send(KIND_LOOKUP, 32'h0000_1234, 17'h10000);
    send(KIND_LOOKUP, 32'hffff_abcd, 17'd0);
    send(KIND_LOOKUP, 32'h0001_0000, 17'd0);
    send(KIND_LOOKUP, 32'h0010_0000, 17'd0);
    drain();
    cfg_write(CFG_POOL_BASE, 16'hffff);
    send(KIND_LOOKUP, 32'hffff_0000, 17'd0);
    drain();
    cfg_write(CFG_REGIONS_ENABLED, 16'h0000);
    send(KIND_MAP,    32'h0000_ffff, 17'd2);
    send(KIND_LOOKUP, 32'h0000_0000, 17'd0);
    drain();
    cfg_write(CFG_REGIONS_ENABLED, 16'h0002);
    cfg_write(CFG_PAGE_LIMIT, 16'h0003);
    cfg_write(CFG_POOL_BASE, 16'h1234);
    send(KIND_MAP,    32'h0020_0000, 17'd4);
    send(KIND_MAP,    32'h0002_8000, 17'h08000);
    send(KIND_MAP,    32'h0003_0000, 17'd1);
    send(KIND_LOOKUP, 32'h0002_0010, 17'd0);
    drain();
    cfg_write(CFG_PAGE_LIMIT, 16'h0000);
    send(KIND_MAP,    32'h0002_0000, 17'd0);
    send(KIND_MAP,    32'hfffe_0000, 17'd0);
    drain();
    cfg_write(CFG_REGIONS_ENABLED, 16'h0001);
    send(KIND_LOOKUP, 32'hffff_0000, 17'd0);
    drain();
    cfg_write(CFG_REGIONS_ENABLED, 16'hffff);
    cfg_write(CFG_PAGE_LIMIT, 16'h001f);
    cfg_write(CFG_SPARE, 16'($urandom));

    for (int stage = 0; stage < 3; stage++) begin
      idle_pct = (stage == 0) ? 27 : (stage == 1) ? 53 : 0;
      repeat (4) begin
        drain();
        random_settings();
        repeat (137) random_item();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (tracker.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(8 * 200_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
